@@ rtl/one_wire_bus_master_unit_defines.svh @@
// ----------------------------------------------------------------------------
// One-wire bus master assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define OWM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define OWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/owm_pkg.sv @@
// ----------------------------------------------------------------------------
// One-wire bus master package
// Shared widths, codes, configuration and result types, duration clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

	localparam int COUNT_WIDTH = 10;
	localparam int CMAX        = (1 << COUNT_WIDTH) - 1;
	localparam int REG_WIDTH   = 10;
	localparam int IDX_WIDTH   = 3;
	localparam int SAMPLE_DELAY = 10;
	localparam int READ_TAIL    = 50;
	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_RESET = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_RESET_LOW    = 3'd0,
		REG_PRESENCE     = 3'd1,
		REG_RESET_TAIL   = 3'd2,
		REG_ONE_LOW      = 3'd3,
		REG_ONE_RELEASE  = 3'd4,
		REG_ZERO_LOW     = 3'd5,
		REG_ZERO_RELEASE = 3'd6,
		REG_READ_LOW     = 3'd7
	} reg_idx_t;

	localparam logic [REG_WIDTH-1:0] RST_RESET_LOW    = 10'd500;
	localparam logic [REG_WIDTH-1:0] RST_PRESENCE     = 10'd70;
	localparam logic [REG_WIDTH-1:0] RST_RESET_TAIL   = 10'd410;
	localparam logic [REG_WIDTH-1:0] RST_ONE_LOW      = 10'd10;
	localparam logic [REG_WIDTH-1:0] RST_ONE_RELEASE  = 10'd55;
	localparam logic [REG_WIDTH-1:0] RST_ZERO_LOW     = 10'd65;
	localparam logic [REG_WIDTH-1:0] RST_ZERO_RELEASE = 10'd5;
	localparam logic [REG_WIDTH-1:0] RST_READ_LOW     = 10'd2;

	typedef struct packed {
		logic [REG_WIDTH-1:0] reset_low_time;
		logic [REG_WIDTH-1:0] presence_wait;
		logic [REG_WIDTH-1:0] reset_tail;
		logic [REG_WIDTH-1:0] one_low_time;
		logic [REG_WIDTH-1:0] one_release_time;
		logic [REG_WIDTH-1:0] zero_low_time;
		logic [REG_WIDTH-1:0] zero_release_time;
		logic [REG_WIDTH-1:0] read_low_time;
	} cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence_error;
		logic [7:0] read_data;
	} res_t;

	// A zero duration counts as one tick; long ones saturate at the counter.
	function automatic logic [COUNT_WIDTH-1:0] clamp_dur(input logic [REG_WIDTH-1:0] v);
		logic [15:0] ext;
		ext = 16'(v);
		if (ext == 16'd0) ext = 16'd1;
		if (ext > 16'(CMAX)) ext = 16'(CMAX);
		return ext[COUNT_WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/owm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// One-wire bus master configuration registers
// Eight timing registers written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [owm_pkg::IDX_WIDTH-1:0] wr_index,
	input  wire logic [owm_pkg::REG_WIDTH-1:0] wr_data,
	output owm_pkg::cfg_t                      cfg
);
	import owm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time    <= RST_RESET_LOW;
			cfg_q.presence_wait     <= RST_PRESENCE;
			cfg_q.reset_tail        <= RST_RESET_TAIL;
			cfg_q.one_low_time      <= RST_ONE_LOW;
			cfg_q.one_release_time  <= RST_ONE_RELEASE;
			cfg_q.zero_low_time     <= RST_ZERO_LOW;
			cfg_q.zero_release_time <= RST_ZERO_RELEASE;
			cfg_q.read_low_time     <= RST_READ_LOW;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_RESET_LOW:    cfg_q.reset_low_time    <= wr_data;
				REG_PRESENCE:     cfg_q.presence_wait     <= wr_data;
				REG_RESET_TAIL:   cfg_q.reset_tail        <= wr_data;
				REG_ONE_LOW:      cfg_q.one_low_time      <= wr_data;
				REG_ONE_RELEASE:  cfg_q.one_release_time  <= wr_data;
				REG_ZERO_LOW:     cfg_q.zero_low_time     <= wr_data;
				REG_ZERO_RELEASE: cfg_q.zero_release_time <= wr_data;
				REG_READ_LOW:     cfg_q.read_low_time     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/owm_core.sv @@
// ----------------------------------------------------------------------------
// One-wire bus master slot sequencer
// Phase, tick counter and shift state; computes one result per tick.
// ----------------------------------------------------------------------------
`default_nettype none
`include "one_wire_bus_master_unit_defines.svh"

module owm_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [1:0]    command,
	input  wire logic [7:0]    data_byte,
	input  wire logic          line_level,
	input  wire owm_pkg::cfg_t cfg,
	output owm_pkg::res_t      res
);
	import owm_pkg::*;

	typedef enum logic [8:0] {
		PH_IDLE     = 9'b000000001,
		PH_RST_LOW  = 9'b000000010,
		PH_RST_WAIT = 9'b000000100,
		PH_RST_TAIL = 9'b000001000,
		PH_WR_LOW   = 9'b000010000,
		PH_WR_REL   = 9'b000100000,
		PH_RD_LOW   = 9'b001000000,
		PH_RD_WAIT  = 9'b010000000,
		PH_RD_TAIL  = 9'b100000000
	} phase_t;

	phase_t                 phase_q, ph;
	logic [COUNT_WIDTH-1:0] tick_count_q, tc, dur;
	logic [COUNT_WIDTH:0]   tc_inc;
	logic [2:0]             bit_index_q, bi;
	logic [7:0]             shift_q, sb;
	logic                   presence_q, pf;
	logic [7:0]             read_q, rr;
	logic                   done, drive;

	always_comb begin
		ph   = phase_q;
		tc   = tick_count_q;
		bi   = bit_index_q;
		sb   = shift_q;
		pf   = presence_q;
		rr   = read_q;
		done = 1'b0;

		// A command only starts an operation from idle.
		if (ph == PH_IDLE) begin
			case (cmd_t'(command))
				CMD_RESET: begin
					ph = PH_RST_LOW;
					tc = '0;
					bi = '0;
				end
				CMD_WRITE: begin
					ph = PH_WR_LOW;
					tc = '0;
					bi = '0;
					sb = data_byte;
				end
				CMD_READ: begin
					ph = PH_RD_LOW;
					tc = '0;
					bi = '0;
					sb = '0;
				end
				default: ;
			endcase
		end

		drive = (ph == PH_RST_LOW) || (ph == PH_WR_LOW) || (ph == PH_RD_LOW);

		case (ph)
			PH_RST_LOW:  dur = clamp_dur(cfg.reset_low_time);
			PH_RST_WAIT: dur = clamp_dur(cfg.presence_wait);
			PH_RST_TAIL: dur = clamp_dur(cfg.reset_tail);
			PH_WR_LOW:   dur = clamp_dur(sb[0] ? cfg.one_low_time : cfg.zero_low_time);
			PH_WR_REL:   dur = clamp_dur(sb[0] ? cfg.one_release_time : cfg.zero_release_time);
			PH_RD_LOW:   dur = clamp_dur(cfg.read_low_time);
			PH_RD_WAIT:  dur = clamp_dur(REG_WIDTH'(SAMPLE_DELAY));
			PH_RD_TAIL:  dur = clamp_dur(REG_WIDTH'(READ_TAIL));
			default:     dur = COUNT_WIDTH'(1);
		endcase

		tc_inc = {1'b0, tc} + (COUNT_WIDTH+1)'(1);

		if (ph != PH_IDLE) begin
			if (tc_inc < {1'b0, dur}) begin
				tc = tc_inc[COUNT_WIDTH-1:0];
			end else begin
				tc = '0;
				case (ph)
					PH_RST_LOW:  ph = PH_RST_WAIT;
					PH_RST_WAIT: begin
						pf = line_level;
						ph = PH_RST_TAIL;
					end
					PH_RST_TAIL: begin
						ph   = PH_IDLE;
						done = 1'b1;
					end
					PH_WR_LOW:   ph = PH_WR_REL;
					PH_WR_REL: begin
						sb = {1'b0, sb[7:1]};
						if (bi == LAST_BIT) begin
							bi   = '0;
							ph   = PH_IDLE;
							done = 1'b1;
						end else begin
							bi = bi + 3'd1;
							ph = PH_WR_LOW;
						end
					end
					PH_RD_LOW:   ph = PH_RD_WAIT;
					PH_RD_WAIT: begin
						sb = {line_level, sb[7:1]};
						ph = PH_RD_TAIL;
					end
					PH_RD_TAIL: begin
						if (bi == LAST_BIT) begin
							rr   = sb;
							bi   = '0;
							ph   = PH_IDLE;
							done = 1'b1;
						end else begin
							bi = bi + 3'd1;
							ph = PH_RD_LOW;
						end
					end
					default:     ph = PH_IDLE;
				endcase
			end
		end

		res.drive_low      = drive;
		res.busy_res       = (ph != PH_IDLE);
		res.done_res       = done;
		res.presence_error = pf;
		res.read_data      = rr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_count_q <= '0;
			bit_index_q  <= '0;
			shift_q      <= '0;
			presence_q   <= 1'b1;
			read_q       <= '0;
		end else if (step) begin
			phase_q      <= ph;
			tick_count_q <= tc;
			bit_index_q  <= bi;
			shift_q      <= sb;
			presence_q   <= pf;
			read_q       <= rr;
		end
	end

	`OWM_ASSERT_IMPL(a_drive_busy, res.drive_low, res.busy_res,
		"line driven low on a tick that leaves the master idle")
	`OWM_ASSERT_NEXT(a_done_idle, step && res.done_res, phase_q == PH_IDLE,
		"operation completed but sequencer did not return to idle")
	`OWM_ASSERT_IMPL(a_tick_bound, 1'b1, tick_count_q != COUNT_WIDTH'(CMAX),
		"tick counter reached its saturation value")
	`OWM_ASSERT_NEXT(a_hold_state, !step, $stable(phase_q) && $stable(tick_count_q),
		"sequencer state moved without a tick")

endmodule

`default_nettype wire

@@ rtl/one_wire_bus_master_unit.sv @@
// ----------------------------------------------------------------------------
// One-wire bus master unit
// A tick beat passes the input register and then the result register; its result
// beat is valid once it sits in the result register.
// Throughput: one tick beat per cycle while out_ready stays high.
// Reset: arst_n clears the pipeline valids, returns the sequencer to idle with
// presence_error high and loads the timing registers with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Tick channel: one beat is one microsecond of bus time.
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    command,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          line_level,
	// Result channel: one beat per tick beat.
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               drive_low,
	output logic                               busy_res,
	output logic                               done_res,
	output logic                               presence_error,
	output logic [7:0]                         read_data,
	// Configuration write channel.
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [owm_pkg::IDX_WIDTH-1:0] cfg_index,
	input  wire logic [owm_pkg::REG_WIDTH-1:0] cfg_data
);
	import owm_pkg::*;

	// Stage 1 holds the accepted tick beat; stage 2 is the result register.
	logic       valid_s1;
	logic [1:0] command_s1;
	logic [7:0] data_byte_s1;
	logic       line_level_s1;
	logic       valid_s2;
	res_t       res_s2;

	cfg_t cfg;
	res_t res_next;
	logic advance;
	logic step;

	// The result register moves whenever it is empty or being drained, and
	// stage 1 refills in the same cycle, so ticks flow back to back.
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	// Configuration writes are always taken and land at once; the timing
	// registers are meant to be written only while no tick beat is in flight.
	assign cfg_ready = 1'b1;

	owm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The sequencer state advances exactly when a tick moves into stage 2.
	owm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.command    (command_s1),
		.data_byte  (data_byte_s1),
		.line_level (line_level_s1),
		.cfg        (cfg),
		.res        (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance)  valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1    <= command;
			data_byte_s1  <= data_byte;
			line_level_s1 <= line_level;
		end
		if (step) res_s2 <= res_next;
	end

	assign out_valid      = valid_s2;
	assign drive_low      = res_s2.drive_low;
	assign busy_res       = res_s2.busy_res;
	assign done_res       = res_s2.done_res;
	assign presence_error = res_s2.presence_error;
	assign read_data      = res_s2.read_data;

endmodule

`default_nettype wire

@@ tb/one_wire_bus_master_checker.sv @@
// ----------------------------------------------------------------------------
// One-wire bus master result checker
// Tracks every accepted tick beat and configuration write, predicts the
// result beat that each tick produces, and compares the result channel
// against those predictions in order.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic [1:0]                    command,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          line_level,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic                          drive_low,
	input  wire logic                          busy_res,
	input  wire logic                          done_res,
	input  wire logic                          presence_error,
	input  wire logic [7:0]                    read_data,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [owm_pkg::IDX_WIDTH-1:0] cfg_index,
	input  wire logic [owm_pkg::REG_WIDTH-1:0] cfg_data,
	output int                                 errors,
	output int                                 pending,
	output logic                               seq_busy,
	output int                                 ops_done,
	output int                                 beats_checked
);
	import owm_pkg::*;

	localparam int REPORT_LIMIT = 20;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_RESET_LOW,
		SEQ_PRESENCE,
		SEQ_RESET_TAIL,
		SEQ_WRITE_LOW,
		SEQ_WRITE_REL,
		SEQ_READ_LOW,
		SEQ_READ_SAMPLE,
		SEQ_READ_TAIL
	} seq_phase_t;

	logic [REG_WIDTH-1:0] timing [1 << IDX_WIDTH];
	seq_phase_t           phase;
	int                   held;
	logic [2:0]           bit_pos;
	logic [7:0]           shifter;
	logic                 presence;
	logic [7:0]           last_read;
	res_t                 owed_results[$];
	int                   fails;
	int                   finished;
	int                   checked;

	// A setting of zero still lasts one tick; nothing outlasts the counter.
	function automatic int ticks_of(input int setting);
		if (setting == 0)
			return 1;
		if (setting > CMAX)
			return CMAX;
		return setting;
	endfunction

	function automatic int phase_length();
		case (phase)
			SEQ_RESET_LOW:   return ticks_of(timing[REG_RESET_LOW]);
			SEQ_PRESENCE:    return ticks_of(timing[REG_PRESENCE]);
			SEQ_RESET_TAIL:  return ticks_of(timing[REG_RESET_TAIL]);
			SEQ_WRITE_LOW:   return ticks_of(shifter[0] ? timing[REG_ONE_LOW] :
				timing[REG_ZERO_LOW]);
			SEQ_WRITE_REL:   return ticks_of(shifter[0] ? timing[REG_ONE_RELEASE] :
				timing[REG_ZERO_RELEASE]);
			SEQ_READ_LOW:    return ticks_of(timing[REG_READ_LOW]);
			SEQ_READ_SAMPLE: return ticks_of(SAMPLE_DELAY);
			SEQ_READ_TAIL:   return ticks_of(READ_TAIL);
			default:         return 1;
		endcase
	endfunction

	// Advances the bus sequence by one microsecond and returns what the
	// block should report for that tick.
	function automatic res_t bus_tick(input cmd_t cmd, input logic [7:0] byte_in,
		input logic line);
		res_t r;
		r = '0;
		if (phase == SEQ_IDLE && cmd != CMD_TICK) begin
			held = 0;
			bit_pos = '0;
			case (cmd)
				CMD_RESET: phase = SEQ_RESET_LOW;
				CMD_WRITE: begin
					shifter = byte_in;
					phase = SEQ_WRITE_LOW;
				end
				CMD_READ: begin
					shifter = '0;
					phase = SEQ_READ_LOW;
				end
				default: ;
			endcase
		end
		r.drive_low = phase inside {SEQ_RESET_LOW, SEQ_WRITE_LOW, SEQ_READ_LOW};
		if (phase != SEQ_IDLE) begin
			if (held + 1 < phase_length()) begin
				held++;
			end else begin
				held = 0;
				case (phase)
					SEQ_RESET_LOW: phase = SEQ_PRESENCE;
					SEQ_PRESENCE: begin
						presence = line;
						phase = SEQ_RESET_TAIL;
					end
					SEQ_RESET_TAIL: begin
						phase = SEQ_IDLE;
						r.done_res = 1'b1;
					end
					SEQ_WRITE_LOW: phase = SEQ_WRITE_REL;
					SEQ_WRITE_REL: begin
						shifter = shifter >> 1;
						if (bit_pos == LAST_BIT) begin
							bit_pos = '0;
							phase = SEQ_IDLE;
							r.done_res = 1'b1;
						end else begin
							bit_pos++;
							phase = SEQ_WRITE_LOW;
						end
					end
					SEQ_READ_LOW: phase = SEQ_READ_SAMPLE;
					SEQ_READ_SAMPLE: begin
						shifter = {line, shifter[7:1]};
						phase = SEQ_READ_TAIL;
					end
					SEQ_READ_TAIL: begin
						if (bit_pos == LAST_BIT) begin
							last_read = shifter;
							bit_pos = '0;
							phase = SEQ_IDLE;
							r.done_res = 1'b1;
						end else begin
							bit_pos++;
							phase = SEQ_READ_LOW;
						end
					end
					default: phase = SEQ_IDLE;
				endcase
			end
		end
		r.busy_res = phase != SEQ_IDLE;
		r.presence_error = presence;
		r.read_data = last_read;
		return r;
	endfunction

	function automatic bit differs(input string field, input logic [7:0] want,
		input logic [7:0] got, input bit loud);
		if (got === want)
			return 1'b0;
		if (loud)
			$display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		bit   bad;
		bit   loud;
		if (!arst_n) begin
			timing[REG_RESET_LOW] = RST_RESET_LOW;
			timing[REG_PRESENCE] = RST_PRESENCE;
			timing[REG_RESET_TAIL] = RST_RESET_TAIL;
			timing[REG_ONE_LOW] = RST_ONE_LOW;
			timing[REG_ONE_RELEASE] = RST_ONE_RELEASE;
			timing[REG_ZERO_LOW] = RST_ZERO_LOW;
			timing[REG_ZERO_RELEASE] = RST_ZERO_RELEASE;
			timing[REG_READ_LOW] = RST_READ_LOW;
			phase = SEQ_IDLE;
			held = 0;
			bit_pos = '0;
			shifter = '0;
			presence = 1'b1;
			last_read = '0;
			owed_results.delete();
			fails = 0;
			finished = 0;
			checked = 0;
		end else begin
			// Results are matched before new ticks are queued, so a result
			// can never be credited to a tick taken in the same cycle.
			if (out_valid && out_ready) begin
				checked++;
				loud = fails < REPORT_LIMIT;
				if (owed_results.size() == 0) begin
					if (loud)
						$display("%0t: result beat expected none, %s %0h done %0h",
							$time, "actual drive_low", drive_low, done_res);
					fails++;
				end else begin
					want = owed_results.pop_front();
					bad = differs("drive_low", 8'(want.drive_low), 8'(drive_low), loud)
						| differs("busy_res", 8'(want.busy_res), 8'(busy_res), loud)
						| differs("done_res", 8'(want.done_res), 8'(done_res), loud)
						| differs("presence_error", 8'(want.presence_error),
							8'(presence_error), loud)
						| differs("read_data", want.read_data, read_data, loud);
					if (bad)
						fails++;
				end
			end
			if (cfg_valid && cfg_ready)
				timing[cfg_index] = cfg_data;
			if (in_valid && in_ready) begin
				want = bus_tick(cmd_t'(command), data_byte, line_level);
				if (want.done_res)
					finished++;
				owed_results.push_back(want);
			end
		end
		errors <= fails;
		pending <= owed_results.size();
		seq_busy <= phase != SEQ_IDLE;
		ops_done <= finished;
		beats_checked <= checked;
	end

endmodule

`default_nettype wire

@@ tb/tb_one_wire_bus_master_unit.sv @@
// ----------------------------------------------------------------------------
// One-wire bus master unit testbench
// Drives microsecond tick beats that carry reset, write byte and read byte
// commands with a random bus line, under the default timing, an all-zero
// setting and a series of short random settings, while a checker predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_one_wire_bus_master_unit;
	import owm_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 11;
	// Extra idle cycles that settle waits after the last result, as margin.
	localparam int SETTLE_CYCLES = 8;
	// Past this many tick beats the run goes without any idling.
	localparam int CALM_TICKS    = 560;
	// The calm tail keeps starting operations until this many tick beats.
	localparam int TOTAL_TICKS   = 620;
	localparam int NUM_REGS      = 1 << IDX_WIDTH;
	// Watchdog limit: far above the slowest run under the longest stalls.
	localparam int TIME_LIMIT    = 80_000_000;

	typedef logic [REG_WIDTH-1:0] timing_t [NUM_REGS];

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           command = CMD_TICK;
	logic [7:0]           data_byte = '0;
	logic                 line_level = 1'b1;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 drive_low;
	logic                 busy_res;
	logic                 done_res;
	logic                 presence_error;
	logic [7:0]           read_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IDX_WIDTH-1:0] cfg_index = '0;
	logic [REG_WIDTH-1:0] cfg_data = '0;

	int   errors;
	int   pending;
	logic seq_busy;
	int   ops_done;
	int   beats_checked;

	// Stimulus bookkeeping.
	bit      calm = 1'b0;
	int      gap_pct = 0;
	int      tick_beats = 0;
	int      settings_used = 1;
	timing_t timing_plan;

	one_wire_bus_master_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.data_byte     (data_byte),
		.line_level    (line_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive_low     (drive_low),
		.busy_res      (busy_res),
		.done_res      (done_res),
		.presence_error(presence_error),
		.read_data     (read_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	one_wire_bus_master_checker line_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.data_byte     (data_byte),
		.line_level    (line_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive_low     (drive_low),
		.busy_res      (busy_res),
		.done_res      (done_res),
		.presence_error(presence_error),
		.read_data     (read_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending),
		.seq_busy      (seq_busy),
		.ops_done      (ops_done),
		.beats_checked (beats_checked)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Watchdog: a hung handshake or a sequencer that never finishes ends here.
	initial begin
		#TIME_LIMIT;
		$display("CHECKS FAILED");
		$finish;
	end

	// The result side holds ready high for stretches of varying length, some
	// of them long, and drops it for short bursts except in the calm tail.
	initial begin
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			if ($urandom_range(7) == 0)
				repeat ($urandom_range(100, 300)) @(posedge clk);
			else
				repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm && $urandom_range(2) != 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	// Offers one tick beat and returns at the edge that accepts it. Every task
	// below is entered just after a rising edge, so each drive lands there.
	// The valid is only lowered for a gap, and a gap always ends at a later
	// edge than the one where it began.
	task automatic send_tick(input cmd_t cmd, input logic [7:0] byte_out);
		if (!calm && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		data_byte <= byte_out;
		line_level <= 1'($urandom_range(1));
		do @(posedge clk); while (!in_ready);
		tick_beats++;
	endtask

	// Ticks inside an operation mostly carry no command, but now and then a
	// stray command shows up that the block has to ignore while it is busy.
	function automatic cmd_t filler_cmd();
		if ($urandom_range(7) == 0)
			return cmd_t'($urandom_range(3));
		return CMD_TICK;
	endfunction

	// Starts one operation and keeps ticking until it is over. The busy flag
	// from the checker trails by one beat, so one extra tick always follows.
	// A stray command on that tick may start a further operation, which the
	// next call or the next settle then runs out.
	task automatic run_op(input cmd_t cmd, input logic [7:0] byte_out);
		case ($urandom_range(2))
			0: gap_pct = 0;
			1: gap_pct = 10;
			default: gap_pct = 35;
		endcase
		send_tick(cmd, byte_out);
		do send_tick(filler_cmd(), 8'($urandom)); while (seq_busy);
	endtask

	// Brings the block back to idle with nothing owed: first wait for every
	// result, then run out any operation that a trailing tick started, using
	// plain ticks only so that the last one cannot start another.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		if (seq_busy) begin
			do send_tick(CMD_TICK, 8'($urandom)); while (seq_busy);
			in_valid <= 1'b0;
			do @(posedge clk); while (pending != 0);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all eight timing registers back to back from timing_plan.
	task automatic program_timing();
		reg_idx_t r;
		r = r.first();
		do begin
			cfg_valid <= 1'b1;
			cfg_index <= r;
			cfg_data <= timing_plan[r];
			do @(posedge clk); while (!cfg_ready);
			r = r.next();
		end while (r != r.first());
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		cmd_t op;
		int   pick;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Reset values first: a few commandless beats, then a
		// read byte with the standard slot timing, which also walks the fixed
		// sample delay and tail eight times.
		repeat (3) send_tick(CMD_TICK, 8'hFF);
		run_op(CMD_READ, 8'h5A);
		settle();

		// A register holding zero must still behave as a one-tick phase.
		foreach (timing_plan[i])
			timing_plan[i] = '0;
		program_timing();
		run_op(CMD_RESET, 8'hFF);
		run_op(CMD_WRITE, 8'h96);
		settle();

		// Random part. Each setting keeps all phases short so that many resets
		// and writes fit in the run; once in a while one register is a little
		// longer. Reads always last hundreds of ticks, so they stay directed.
		while (!calm) begin
			foreach (timing_plan[i])
				timing_plan[i] = REG_WIDTH'($urandom_range(3));
			if ($urandom_range(4) == 0)
				timing_plan[$urandom_range(NUM_REGS - 1)] = REG_WIDTH'($urandom_range(12));
			program_timing();
			repeat ($urandom_range(2, 4)) begin
				pick = $urandom_range(9);
				op = (pick < 4) ? CMD_RESET : CMD_WRITE;
				run_op(op, 8'($urandom));
				repeat ($urandom_range(3))
					send_tick(CMD_TICK, 8'($urandom));
			end
			settle();
			calm = tick_beats >= CALM_TICKS;
		end

		// Calm tail: the last setting stays and every beat goes back to back.
		while (tick_beats < TOTAL_TICKS) begin
			pick = $urandom_range(9);
			op = (pick < 4) ? CMD_RESET : CMD_WRITE;
			run_op(op, 8'($urandom));
		end
		settle();

		$display("Run covered %0d tick beats and %0d finished bus operations",
			tick_beats, ops_done);
		$display("over %0d timing settings; %0d result beats were compared.",
			settings_used, beats_checked);
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
